### hw/rtl/bbrc_pkg.sv
// Shared types and constants for the reference-counted block buffer table.
// Used by bbrc_ram users, bbrc_scan and block_buffer_refcount_table.
package bbrc_pkg;

    localparam int NUM_SLOTS  = 32;
    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SCAN_SLOTS = (NUM_SLOTS < 32) ? NUM_SLOTS : 32;
    localparam int IDX_EXT_W  = 11;

    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] REQ_GET     = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_PIN     = 2'd2;
    localparam logic [1:0] REQ_UNPIN   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_ZERO     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] device;
        logic [31:0] block_number;
        logic [4:0]  slot_in;
    } t_req;

    typedef struct packed {
        logic [4:0]         slot_out;
        logic               hit;
        logic               needs_read;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count_after;
    } t_result;

    // One slot entry as stored in the table memory
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
        logic [15:0]        device;
        logic [31:0]        block;
    } t_word;

    localparam int WORD_W = $bits(t_word);

    // Outcome of a get scan
    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  hit_idx;
        logic [COUNT_W-1:0] hit_count;
        logic               hit_valid;
        logic               free;
        logic [SLOT_W-1:0]  free_idx;
    } t_scan;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_READ,
        S_APPLY
    } t_state;

endpackage

### hw/rtl/bbrc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bbrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(DEPTH)-1:0]       i_waddr,
    input  logic [WIDTH-1:0]               i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(DEPTH)-1:0]       i_raddr,
    output logic [WIDTH-1:0]               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bbrc_scan.sv
// Get scan tracker: watches the stream of table reads and keeps the first
// held slot whose tags match and the first slot with a zero count.
// Depends on bbrc_pkg.
module bbrc_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_vld,
    input  logic [bbrc_pkg::SLOT_W-1:0]   i_idx,
    input  bbrc_pkg::t_word               i_word,
    input  logic [15:0]                   i_device,
    input  logic [31:0]                   i_block,
    output bbrc_pkg::t_scan               o_scan
);

    bbrc_pkg::t_scan r_scan, n_scan;
    logic            match;
    logic            is_free;

    always_comb begin
        match   = (i_word.count != '0) && (i_word.device == i_device)
                  && (i_word.block == i_block);
        is_free = (i_word.count == '0);
        n_scan  = r_scan;
        if (i_clear) begin
            n_scan = '0;
        end else if (i_vld) begin
            // keep only the lowest slot of each kind
            if (match && !r_scan.hit) begin
                n_scan.hit       = 1'b1;
                n_scan.hit_idx   = i_idx;
                n_scan.hit_count = i_word.count;
                n_scan.hit_valid = i_word.valid;
            end
            if (is_free && !r_scan.free) begin
                n_scan.free     = 1'b1;
                n_scan.free_idx = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan <= n_scan;
        end
    end

    assign o_scan = r_scan;

endmodule

### hw/rtl/block_buffer_refcount_table.sv
// Top level of the reference-counted block buffer table.
// Depends on bbrc_pkg, bbrc_ram and bbrc_scan.
//
// Usage:
//   Present a request on i_req and raise start; the transaction is taken at
//   the clock edge where start is high and busy is low. busy stays high
//   until the request is finished. The result appears on o_result for
//   exactly one cycle with o_strobe high; the receiver cannot stall it.
//   A new request may be taken in the same cycle that o_strobe is high.
//   A get steps through S_SCAN, S_DRAIN and S_APPLY; release, pin and
//   unpin step through S_READ and S_APPLY. The result is registered at
//   the end of S_APPLY.
//   A get reads every slot entry through the single read port of the table
//   memory, one entry per cycle, then writes back at most one entry; that scan
//   sets the rate. Release, pin and unpin read one entry and write at most one.
//   Reset clears the per-slot written flags, so every slot reads as
//   count zero and not valid; no clearing pass over the memory is needed
//   and a request may start in the first cycle after reset.
module block_buffer_refcount_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  bbrc_pkg::t_req    i_req,
    output logic              busy,
    output logic              o_strobe,
    output bbrc_pkg::t_result o_result
);

    localparam logic [bbrc_pkg::SLOT_W-1:0] SCAN_LAST =
        bbrc_pkg::SLOT_W'(bbrc_pkg::SCAN_SLOTS - 1);

    bbrc_pkg::t_state  r_state, n_state;
    bbrc_pkg::t_req    r_req;
    logic [bbrc_pkg::SLOT_W-1:0]  r_addr, n_addr;
    logic                         r_scan_vld;
    logic [bbrc_pkg::SLOT_W-1:0]  r_rd_idx;
    logic [bbrc_pkg::NUM_SLOTS-1:0] r_init, n_init;
    logic                         r_strobe;
    bbrc_pkg::t_result            r_result, n_result;

    logic                         accept;
    logic                         ram_re;
    logic [bbrc_pkg::SLOT_W-1:0]  ram_raddr;
    logic [bbrc_pkg::WORD_W-1:0]  ram_q;
    logic                         ram_we;
    logic                         wr_req;
    logic [bbrc_pkg::SLOT_W-1:0]  wr_addr;
    bbrc_pkg::t_word              wr_word;
    bbrc_pkg::t_word              q_word;
    bbrc_pkg::t_scan              scan;
    logic                         scan_clear;
    logic [bbrc_pkg::IDX_EXT_W-1:0] slot_ext;
    logic [bbrc_pkg::SLOT_W-1:0]  slot_addr;
    logic                         slot_in_range;

    assign busy     = (r_state != bbrc_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    assign slot_ext      = bbrc_pkg::IDX_EXT_W'(r_req.slot_in);
    assign slot_addr     = slot_ext[bbrc_pkg::SLOT_W-1:0];
    assign slot_in_range = slot_ext < bbrc_pkg::IDX_EXT_W'(bbrc_pkg::NUM_SLOTS);

    // Never-written entries read as the reset value
    assign q_word = r_init[r_rd_idx] ? bbrc_pkg::t_word'(ram_q) : '0;

    assign scan_clear = accept;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bbrc_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == bbrc_pkg::REQ_GET) begin
                        n_state = bbrc_pkg::S_SCAN;
                    end else begin
                        n_state = bbrc_pkg::S_READ;
                    end
                end
            end
            bbrc_pkg::S_SCAN: begin
                if (r_addr == SCAN_LAST) begin
                    n_state = bbrc_pkg::S_DRAIN;
                end
            end
            bbrc_pkg::S_DRAIN: n_state = bbrc_pkg::S_APPLY;
            bbrc_pkg::S_READ:  n_state = bbrc_pkg::S_APPLY;
            bbrc_pkg::S_APPLY: n_state = bbrc_pkg::S_IDLE;
            default:           n_state = bbrc_pkg::S_IDLE;
        endcase
    end

    // Memory read control
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = slot_addr;
        n_addr    = r_addr;
        case (r_state)
            bbrc_pkg::S_IDLE: begin
                n_addr = '0;
            end
            bbrc_pkg::S_SCAN: begin
                ram_re    = 1'b1;
                ram_raddr = r_addr;
                n_addr    = r_addr + 1'b1;
            end
            bbrc_pkg::S_READ: begin
                ram_re = 1'b1;
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    // Result and write-back for the finishing request
    always_comb begin
        wr_req   = 1'b0;
        wr_addr  = slot_addr;
        wr_word  = q_word;
        n_result = '0;
        if (r_req.req_type == bbrc_pkg::REQ_GET) begin
            if (scan.hit) begin
                n_result.slot_out = 5'(scan.hit_idx);
                n_result.hit      = 1'b1;
                wr_addr           = scan.hit_idx;
                if (scan.hit_count == bbrc_pkg::COUNT_MAX) begin
                    n_result.status      = bbrc_pkg::ST_OVERFLOW;
                    n_result.count_after = bbrc_pkg::COUNT_MAX;
                end else begin
                    wr_req               = 1'b1;
                    wr_word.valid        = 1'b1;
                    wr_word.count        = scan.hit_count + 1'b1;
                    wr_word.device       = r_req.device;
                    wr_word.block        = r_req.block_number;
                    n_result.needs_read  = !scan.hit_valid;
                    n_result.status      = bbrc_pkg::ST_OK;
                    n_result.count_after = scan.hit_count + 1'b1;
                end
            end else if (scan.free) begin
                // claim the free slot; the caller fills it from disk
                wr_req               = 1'b1;
                wr_addr              = scan.free_idx;
                wr_word.valid        = 1'b1;
                wr_word.count        = bbrc_pkg::COUNT_W'(1);
                wr_word.device       = r_req.device;
                wr_word.block        = r_req.block_number;
                n_result.slot_out    = 5'(scan.free_idx);
                n_result.needs_read  = 1'b1;
                n_result.status      = bbrc_pkg::ST_OK;
                n_result.count_after = bbrc_pkg::COUNT_W'(1);
            end else begin
                n_result.status = bbrc_pkg::ST_NO_FREE;
            end
        end else begin
            n_result.slot_out = r_req.slot_in;
            if (!slot_in_range) begin
                n_result.status = bbrc_pkg::ST_ZERO;
            end else if (r_req.req_type == bbrc_pkg::REQ_PIN) begin
                if (q_word.count == bbrc_pkg::COUNT_MAX) begin
                    n_result.status      = bbrc_pkg::ST_OVERFLOW;
                    n_result.count_after = bbrc_pkg::COUNT_MAX;
                end else begin
                    wr_req               = 1'b1;
                    wr_word.count        = q_word.count + 1'b1;
                    n_result.status      = bbrc_pkg::ST_OK;
                    n_result.count_after = q_word.count + 1'b1;
                end
            end else begin
                if (q_word.count == '0) begin
                    n_result.status = bbrc_pkg::ST_ZERO;
                end else begin
                    wr_req               = 1'b1;
                    wr_word.count        = q_word.count - 1'b1;
                    n_result.status      = bbrc_pkg::ST_OK;
                    n_result.count_after = q_word.count - 1'b1;
                end
            end
        end
    end

    assign ram_we = (r_state == bbrc_pkg::S_APPLY) && wr_req;

    always_comb begin
        n_init = r_init;
        if (ram_we) begin
            n_init[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bbrc_pkg::S_IDLE;
            r_scan_vld <= 1'b0;
            r_init     <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_scan_vld <= (r_state == bbrc_pkg::S_SCAN);
            r_init     <= n_init;
            r_strobe   <= (r_state == bbrc_pkg::S_APPLY);
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (accept) begin
            r_req <= i_req;
        end
        if (ram_re) begin
            r_rd_idx <= ram_raddr;
        end
        if (r_state == bbrc_pkg::S_APPLY) begin
            r_result <= n_result;
        end
    end

    bbrc_ram #(
        .WIDTH (bbrc_pkg::WORD_W),
        .DEPTH (bbrc_pkg::NUM_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_word),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    bbrc_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (scan_clear),
        .i_vld    (r_scan_vld),
        .i_idx    (r_rd_idx),
        .i_word   (q_word),
        .i_device (r_req.device),
        .i_block  (r_req.block_number),
        .o_scan   (scan)
    );

endmodule

### sim/tb_block_buffer_refcount_table.sv
// Self-checking testbench for block_buffer_refcount_table: a directed table,
// a fill of every free slot and a random mix, scored by typed rows or a predictor.
// Depends on bbrc_pkg and the block_buffer_refcount_table RTL.
module tb_block_buffer_refcount_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1200;
    localparam int TAG_POOL     = 40;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int REPORT_MAX   = 10;

    typedef enum logic [1:0] {
        ROW_SINGLE,
        ROW_FILL_TABLE
    } t_row_kind;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BLEND,
        MIX_NOISE
    } t_mix;

    typedef struct packed {
        t_row_kind          kind;
        logic               typed;
        bbrc_pkg::t_req     req;
        bbrc_pkg::t_result  res;
    } t_row;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    bbrc_pkg::t_req    i_req   = '0;
    logic              busy;
    logic              o_strobe;
    bbrc_pkg::t_result o_result;

    // Predicted slot table
    logic [15:0]                  dev_tbl[bbrc_pkg::NUM_SLOTS];
    logic [31:0]                  blk_tbl[bbrc_pkg::NUM_SLOTS];
    logic [bbrc_pkg::COUNT_W-1:0] cnt_tbl[bbrc_pkg::NUM_SLOTS];
    bit                           valid_tbl[bbrc_pkg::NUM_SLOTS];
    bit                           tag_written[bbrc_pkg::NUM_SLOTS];

    logic [15:0] pool_dev[TAG_POOL];
    logic [31:0] pool_blk[TAG_POOL];

    bbrc_pkg::t_result pending_results[$];
    t_row              directed_rows[$];
    int                mismatches  = 0;
    int unsigned       cycle_count = 0;

    block_buffer_refcount_table u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("block_buffer_refcount_table: mismatch");
            $finish;
        end
    end

    // Score every strobed result against the oldest expected result
    always @(posedge i_clk) begin : check_results
        bbrc_pkg::t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result with no transaction pending: %p",
                             $realtime, o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result.slot_out !== want.slot_out || o_result.hit !== want.hit ||
                    o_result.needs_read !== want.needs_read ||
                    o_result.status !== want.status ||
                    o_result.count_after !== want.count_after) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"%0t: expected slot %0d hit %0b rd %0b st %0d cnt %0d,",
                                  " got slot %0d hit %0b rd %0b st %0d cnt %0d"},
                                 $realtime, want.slot_out, want.hit, want.needs_read,
                                 want.status, want.count_after, o_result.slot_out,
                                 o_result.hit, o_result.needs_read, o_result.status,
                                 o_result.count_after);
                end
            end
        end
    end

    // Update the predicted table for one request and return its result
    function automatic bbrc_pkg::t_result apply_to_table(bbrc_pkg::t_req r);
        bbrc_pkg::t_result res;
        int                found;
        res   = '0;
        found = -1;
        if (r.req_type == bbrc_pkg::REQ_GET) begin
            for (int i = 0; i < bbrc_pkg::SCAN_SLOTS; i++)
                if (found < 0 && cnt_tbl[i] != '0 && dev_tbl[i] == r.device &&
                    blk_tbl[i] == r.block_number)
                    found = i;
            if (found >= 0) begin
                res.slot_out = 5'(found);
                res.hit      = 1'b1;
                if (cnt_tbl[found] == bbrc_pkg::COUNT_MAX) begin
                    res.status      = bbrc_pkg::ST_OVERFLOW;
                    res.count_after = bbrc_pkg::COUNT_MAX;
                end else begin
                    cnt_tbl[found]   = cnt_tbl[found] + 1'b1;
                    res.needs_read   = !valid_tbl[found];
                    valid_tbl[found] = 1'b1;
                    res.status       = bbrc_pkg::ST_OK;
                    res.count_after  = cnt_tbl[found];
                end
            end else begin
                for (int i = 0; i < bbrc_pkg::SCAN_SLOTS; i++)
                    if (found < 0 && cnt_tbl[i] == '0)
                        found = i;
                if (found >= 0) begin
                    dev_tbl[found]     = r.device;
                    blk_tbl[found]     = r.block_number;
                    cnt_tbl[found]     = bbrc_pkg::COUNT_W'(1);
                    valid_tbl[found]   = 1'b1;
                    tag_written[found] = 1'b1;
                    res.slot_out       = 5'(found);
                    res.needs_read     = 1'b1;
                    res.status         = bbrc_pkg::ST_OK;
                    res.count_after    = bbrc_pkg::COUNT_W'(1);
                end else begin
                    res.status = bbrc_pkg::ST_NO_FREE;
                end
            end
        end else begin
            res.slot_out = r.slot_in;
            if (int'(r.slot_in) >= bbrc_pkg::NUM_SLOTS) begin
                res.status = bbrc_pkg::ST_ZERO;
            end else if (r.req_type == bbrc_pkg::REQ_PIN) begin
                if (cnt_tbl[r.slot_in] == bbrc_pkg::COUNT_MAX) begin
                    res.status      = bbrc_pkg::ST_OVERFLOW;
                    res.count_after = bbrc_pkg::COUNT_MAX;
                end else begin
                    cnt_tbl[r.slot_in] = cnt_tbl[r.slot_in] + 1'b1;
                    res.status         = bbrc_pkg::ST_OK;
                    res.count_after    = cnt_tbl[r.slot_in];
                end
            end else begin
                if (cnt_tbl[r.slot_in] == '0) begin
                    res.status = bbrc_pkg::ST_ZERO;
                end else begin
                    cnt_tbl[r.slot_in] = cnt_tbl[r.slot_in] - 1'b1;
                    res.status         = bbrc_pkg::ST_OK;
                    res.count_after    = cnt_tbl[r.slot_in];
                end
            end
        end
        return res;
    endfunction

    function automatic bbrc_pkg::t_req mk_req(logic [1:0] op, logic [15:0] dev,
                                              logic [31:0] blk, logic [4:0] slot);
        bbrc_pkg::t_req r;
        r.req_type     = op;
        r.device       = dev;
        r.block_number = blk;
        r.slot_in      = slot;
        return r;
    endfunction

    function automatic bbrc_pkg::t_result mk_res(logic [4:0] slot, logic hit, logic rd,
                                                 logic [1:0] status,
                                                 logic [bbrc_pkg::COUNT_W-1:0] cnt);
        bbrc_pkg::t_result r;
        r.slot_out    = slot;
        r.hit         = hit;
        r.needs_read  = rd;
        r.status      = status;
        r.count_after = cnt;
        return r;
    endfunction

    task automatic add_row(t_row_kind kind, logic typed, bbrc_pkg::t_req req,
                           bbrc_pkg::t_result res);
        t_row row;
        row.kind  = kind;
        row.typed = typed;
        row.req   = req;
        row.res   = res;
        directed_rows.push_back(row);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // Random request; pins go only to slots whose tags have been written
    function automatic bbrc_pkg::t_req pick_request(t_mix mode);
        bbrc_pkg::t_req r;
        int             roll;
        int             get_pct;
        int             pin_pct;
        int             first;
        int             idx;
        int             p;
        bit             chosen;
        r.device       = 16'($urandom);
        r.block_number = $urandom;
        r.slot_in      = 5'($urandom_range(0, 31));
        chosen         = 1'b0;
        case (mode)
            MIX_FILL: begin
                get_pct = 75;
                pin_pct = 10;
            end
            MIX_DRAIN: begin
                get_pct = 15;
                pin_pct = 10;
            end
            MIX_BLEND: begin
                get_pct = 40;
                pin_pct = 20;
            end
            default: begin
                get_pct = 25;
                pin_pct = 25;
            end
        endcase
        roll  = $urandom_range(0, 99);
        first = $urandom_range(0, bbrc_pkg::NUM_SLOTS - 1);
        if (roll < get_pct) begin
            r.req_type = bbrc_pkg::REQ_GET;
            p    = $urandom_range(0, TAG_POOL - 1);
            roll = $urandom_range(0, 99);
            if (mode != MIX_NOISE && roll < 85) begin
                r.device = pool_dev[p];
                if (roll < 70)
                    r.block_number = pool_blk[p];
            end
        end else if (roll < get_pct + pin_pct) begin
            r.req_type = bbrc_pkg::REQ_PIN;
            if (int'(r.slot_in) < bbrc_pkg::NUM_SLOTS && !tag_written[r.slot_in]) begin
                for (int k = 0; k < bbrc_pkg::NUM_SLOTS; k++) begin
                    idx = (first + k) % bbrc_pkg::NUM_SLOTS;
                    if (!chosen && tag_written[idx]) begin
                        chosen    = 1'b1;
                        r.slot_in = 5'(idx);
                    end
                end
                if (!chosen)
                    r.req_type = bbrc_pkg::REQ_GET;
            end
        end else begin
            r.req_type = $urandom_range(0, 1) ? bbrc_pkg::REQ_RELEASE : bbrc_pkg::REQ_UNPIN;
            if (mode != MIX_NOISE && $urandom_range(0, 99) < 80) begin
                for (int k = 0; k < bbrc_pkg::NUM_SLOTS; k++) begin
                    idx = (first + k) % bbrc_pkg::NUM_SLOTS;
                    if (!chosen && cnt_tbl[idx] != '0) begin
                        chosen    = 1'b1;
                        r.slot_in = 5'(idx);
                    end
                end
            end
        end
        return r;
    endfunction

    // Present one transaction, predict it on acceptance, then drop start for any gap
    task automatic send_request(bbrc_pkg::t_req r, bit typed, bbrc_pkg::t_result typed_res,
                                int gap);
        bbrc_pkg::t_result predicted;
        logic [63:0]       junk;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!(start && !busy));
        predicted = apply_to_table(r);
        pending_results.push_back(typed ? typed_res : predicted);
        if (gap > 0) begin
            junk  = {$urandom, $urandom};
            start <= 1'b0;
            i_req <= junk[$bits(bbrc_pkg::t_req)-1:0];
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        bbrc_pkg::t_req r;
        t_mix           mode;
        bit             quiet;
        bit             has_free;
        int             ep_len;
        int             episode;
        int             random_done;
        int             k;

        for (int i = 0; i < bbrc_pkg::NUM_SLOTS; i++) begin
            dev_tbl[i]     = '0;
            blk_tbl[i]     = '0;
            cnt_tbl[i]     = '0;
            valid_tbl[i]   = 1'b0;
            tag_written[i] = 1'b0;
        end
        for (int i = 0; i < TAG_POOL; i++) begin
            pool_dev[i] = 16'($urandom);
            pool_blk[i] = $urandom;
        end

        // Empty table, tag extremes, partial tag matches, reuse of lowest free slot
        add_row(ROW_SINGLE, 1'b1, mk_req(bbrc_pkg::REQ_RELEASE, 16'h0, 32'h0, 5'd0),
                mk_res(5'd0, 1'b0, 1'b0, bbrc_pkg::ST_ZERO, 16'd0));
        add_row(ROW_SINGLE, 1'b1, mk_req(bbrc_pkg::REQ_UNPIN, 16'h0, 32'h0, 5'd31),
                mk_res(5'd31, 1'b0, 1'b0, bbrc_pkg::ST_ZERO, 16'd0));
        add_row(ROW_SINGLE, 1'b1,
                mk_req(bbrc_pkg::REQ_GET, 16'h0000, 32'h0000_0000, 5'd0),
                mk_res(5'd0, 1'b0, 1'b1, bbrc_pkg::ST_OK, 16'd1));
        add_row(ROW_SINGLE, 1'b1,
                mk_req(bbrc_pkg::REQ_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd31),
                mk_res(5'd1, 1'b0, 1'b1, bbrc_pkg::ST_OK, 16'd1));
        add_row(ROW_SINGLE, 1'b1,
                mk_req(bbrc_pkg::REQ_GET, 16'h0000, 32'h0000_0000, 5'd17),
                mk_res(5'd0, 1'b1, 1'b0, bbrc_pkg::ST_OK, 16'd2));
        add_row(ROW_SINGLE, 1'b1,
                mk_req(bbrc_pkg::REQ_GET, 16'hFFFF, 32'h0000_0000, 5'd0),
                mk_res(5'd2, 1'b0, 1'b1, bbrc_pkg::ST_OK, 16'd1));
        add_row(ROW_SINGLE, 1'b1,
                mk_req(bbrc_pkg::REQ_GET, 16'h0000, 32'hFFFF_FFFF, 5'd0),
                mk_res(5'd3, 1'b0, 1'b1, bbrc_pkg::ST_OK, 16'd1));
        add_row(ROW_SINGLE, 1'b1,
                mk_req(bbrc_pkg::REQ_PIN, 16'hFFFF, 32'hFFFF_FFFF, 5'd1),
                mk_res(5'd1, 1'b0, 1'b0, bbrc_pkg::ST_OK, 16'd2));
        add_row(ROW_SINGLE, 1'b1, mk_req(bbrc_pkg::REQ_UNPIN, 16'h0, 32'h0, 5'd1),
                mk_res(5'd1, 1'b0, 1'b0, bbrc_pkg::ST_OK, 16'd1));
        add_row(ROW_SINGLE, 1'b1, mk_req(bbrc_pkg::REQ_RELEASE, 16'h0, 32'h0, 5'd1),
                mk_res(5'd1, 1'b0, 1'b0, bbrc_pkg::ST_OK, 16'd0));
        add_row(ROW_SINGLE, 1'b1, mk_req(bbrc_pkg::REQ_RELEASE, 16'h0, 32'h0, 5'd1),
                mk_res(5'd1, 1'b0, 1'b0, bbrc_pkg::ST_ZERO, 16'd0));
        add_row(ROW_SINGLE, 1'b1, mk_req(bbrc_pkg::REQ_PIN, 16'h0, 32'h0, 5'd1),
                mk_res(5'd1, 1'b0, 1'b0, bbrc_pkg::ST_OK, 16'd1));
        add_row(ROW_SINGLE, 1'b0,
                mk_req(bbrc_pkg::REQ_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd0), '0);
        add_row(ROW_SINGLE, 1'b0, mk_req(bbrc_pkg::REQ_RELEASE, 16'h0, 32'h0, 5'd1), '0);
        add_row(ROW_SINGLE, 1'b0, mk_req(bbrc_pkg::REQ_UNPIN, 16'h0, 32'h0, 5'd1), '0);
        add_row(ROW_SINGLE, 1'b1,
                mk_req(bbrc_pkg::REQ_GET, 16'h1234, 32'h89AB_CDEF, 5'd0),
                mk_res(5'd1, 1'b0, 1'b1, bbrc_pkg::ST_OK, 16'd1));
        // Free slot 3 again so the fill below reuses it
        add_row(ROW_SINGLE, 1'b1, mk_req(bbrc_pkg::REQ_UNPIN, 16'h0, 32'h0, 5'd3),
                mk_res(5'd3, 1'b0, 1'b0, bbrc_pkg::ST_OK, 16'd0));
        // Claim every remaining slot, then miss with no free slot
        add_row(ROW_FILL_TABLE, 1'b0,
                mk_req(bbrc_pkg::REQ_GET, 16'h0055, 32'h0000_0100, 5'd0), '0);
        add_row(ROW_SINGLE, 1'b1,
                mk_req(bbrc_pkg::REQ_GET, 16'h0055, 32'hFFFF_FFFE, 5'd9),
                mk_res(5'd0, 1'b0, 1'b0, bbrc_pkg::ST_NO_FREE, 16'd0));
        add_row(ROW_SINGLE, 1'b1,
                mk_req(bbrc_pkg::REQ_GET, 16'h0000, 32'h0000_0000, 5'd0),
                mk_res(5'd0, 1'b1, 1'b0, bbrc_pkg::ST_OK, 16'd3));
        add_row(ROW_SINGLE, 1'b0, mk_req(bbrc_pkg::REQ_PIN, 16'h0, 32'h0, 5'd31), '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_SINGLE:
                    send_request(directed_rows[i].req, directed_rows[i].typed,
                                 directed_rows[i].res, pick_gap());
                default: begin
                    k = 0;
                    has_free = 1'b1;
                    while (has_free) begin
                        r = directed_rows[i].req;
                        r.block_number = r.block_number + k;
                        send_request(r, 1'b0, '0, pick_gap());
                        k++;
                        has_free = 1'b0;
                        for (int s = 0; s < bbrc_pkg::SCAN_SLOTS; s++)
                            if (cnt_tbl[s] == '0)
                                has_free = 1'b1;
                    end
                end
            endcase
        end

        episode     = 0;
        random_done = 0;
        while (random_done < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2: mode = MIX_FILL;
                3, 4, 5: mode = MIX_DRAIN;
                6, 7, 8: mode = MIX_BLEND;
                default: mode = MIX_NOISE;
            endcase
            ep_len = $urandom_range(10, 80);
            quiet  = ($urandom_range(0, 3) == 0);
            // Hold off until every pending result is back
            if (episode == 0 || $urandom_range(0, 5) == 0) begin
                start <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end
            for (int n = 0; n < ep_len && random_done < RANDOM_ITEMS; n++) begin
                send_request(pick_request(mode), 1'b0, '0, quiet ? 0 : pick_gap());
                random_done++;
            end
            episode++;
        end

        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("block_buffer_refcount_table: match");
        end else begin
            $display("block_buffer_refcount_table: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/bbrc_pkg.sv
hw/rtl/bbrc_ram.sv
hw/rtl/bbrc_scan.sv
hw/rtl/block_buffer_refcount_table.sv
sim/tb_block_buffer_refcount_table.sv
